@@ hdl/pfre_pkg.sv @@
// Shared types, constants and helpers for the planar framebuffer raster engine.
// No dependencies; every other file of the block but pfre_ram imports this package.
`default_nettype none

package pfre_pkg;

  // Default geometry: 80 byte columns of eight pixels, 400 rows.
  localparam int LINE_BYTES_DEF = 80;
  localparam int ROWS_DEF       = 400;

  localparam int WORD_W = 32;

  // Request codes.
  localparam logic [1:0] OP_DRAW_PIXEL = 2'd0;
  localparam logic [1:0] OP_READ_PIXEL = 2'd1;
  localparam logic [1:0] OP_HSPAN      = 2'd2;
  localparam logic [1:0] OP_VSPAN      = 2'd3;

  // Configuration register byte addresses.
  localparam logic [1:0] REG_DRAW_MODE = 2'd0;

  typedef struct packed {
    logic [1:0] op;
    logic [9:0] x_start;
    logic [9:0] x_end;
    logic [8:0] y_start;
    logic [8:0] y_end;
    logic [3:0] color;
  } req_t;

  typedef struct packed {
    logic [3:0] pixel_value;
    logic       bad_request;
  } res_t;

  // Byte mask copied into all four plane lanes.
  function automatic logic [WORD_W-1:0] spread_mask(input logic [7:0] m);
    return {4{m}};
  endfunction

  // Lanes whose colour bit is set become all ones.
  function automatic logic [WORD_W-1:0] color_lanes(input logic [3:0] c);
    return {{8{c[3]}}, {8{c[2]}}, {8{c[1]}}, {8{c[0]}}};
  endfunction

endpackage

`default_nettype wire

@@ hdl/planar_framebuffer_raster_engine_core.sv @@
// Flow: a request is checked in S_CHECK, walked in S_RUN, drained in S_DRAIN and offered in
// S_DONE; a refused request goes from S_CHECK straight to S_DONE. The next beat is taken only
// after the previous result has gone to the output register; the walk moves one store
// word read and written back per cycle through the single-port-pair RAM.
// Reset: synchronous; a clearing pass writes zero to all LINE_BYTES*ROWS words with
// s_tready low; draw_mode resets to copy.
// Top level: APB register, input unpacking and output register. Depends on pfre_pkg, pfre_engine.
`default_nettype none

module planar_framebuffer_raster_engine_core import pfre_pkg::*; #(
  parameter int LINE_BYTES = LINE_BYTES_DEF,
  parameter int ROWS       = ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // x_start, x_end, y_start, y_end, color, zero pad
  input  wire logic [1:0]  s_tuser,  // op
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,  // pixel_value, zero pad
  output logic             m_tuser   // bad_request
);

  logic draw_mode;
  req_t req;
  logic res_valid;
  logic res_ready;
  res_t res;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_DRAW_MODE) ? {31'b0, draw_mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      draw_mode <= 1'b0;
    end else if (psel && penable && pwrite && paddr == REG_DRAW_MODE) begin
      draw_mode <= pwdata[0];
    end
  end

  assign req = '{op:      s_tuser,
                 x_start: s_tdata[9:0],
                 x_end:   s_tdata[19:10],
                 y_start: s_tdata[28:20],
                 y_end:   s_tdata[37:29],
                 color:   s_tdata[41:38]};

  // output register: the engine may take the next beat while a result waits
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {4'b0, res.pixel_value};
      m_tuser <= res.bad_request;
    end
  end

  pfre_engine #(
    .LINE_BYTES (LINE_BYTES),
    .ROWS       (ROWS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .draw_mode (draw_mode),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

`default_nettype wire

@@ hdl/pfre_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read data.
// Depends on nothing.
`default_nettype none

module pfre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/pfre_engine.sv @@
// Request sequencer and read-modify-write datapath around the plane store.
// Depends on pfre_pkg and pfre_ram.
`default_nettype none

module pfre_engine import pfre_pkg::*; #(
  parameter int LINE_BYTES = LINE_BYTES_DEF,
  parameter int ROWS       = ROWS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic draw_mode,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      res_valid,
  input  wire logic res_ready,
  output res_t      res
);

  localparam int DEPTH      = LINE_BYTES * ROWS;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PIXEL_COLS = LINE_BYTES * 8;
  localparam int CW         = 12;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CHECK = 6'b000100,
    S_RUN   = 6'b001000,
    S_DRAIN = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t            state;
  req_t              req_q;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     addr;
  logic [8:0]        rem;
  logic              first;
  logic              bad_q;
  logic [3:0]        value_q;

  // second stage of the read-modify-write pipe
  logic              p_valid;
  logic              p_write;
  logic [AW-1:0]     p_addr;
  logic [7:0]        p_mask;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  logic              bad;
  logic [AW-1:0]     base;
  logic [6:0]        col_span;
  logic [8:0]        row_span;
  logic [8:0]        rem_init;
  logic [2:0]        lo;
  logic [2:0]        hi;
  logic [7:0]        mask;
  logic [AW-1:0]     step;
  logic [WORD_W-1:0] m_word;
  logic [WORD_W-1:0] c_word;
  logic [3:0]        pix;

  // request check, start address and word count
  always_comb begin
    bad = (CW'(req_q.x_start) >= CW'(PIXEL_COLS)) || (CW'(req_q.y_start) >= CW'(ROWS));
    if (req_q.op == OP_HSPAN) begin
      bad = bad || (CW'(req_q.x_end) >= CW'(PIXEL_COLS)) || (req_q.x_end < req_q.x_start);
    end
    if (req_q.op == OP_VSPAN) begin
      bad = bad || (CW'(req_q.y_end) >= CW'(ROWS)) || (req_q.y_end < req_q.y_start);
    end
    base     = AW'(AW'(req_q.y_start) * AW'(LINE_BYTES)) + AW'(req_q.x_start[9:3]);
    col_span = req_q.x_end[9:3] - req_q.x_start[9:3];
    row_span = req_q.y_end - req_q.y_start;
    case (req_q.op)
      OP_HSPAN: rem_init = {2'b00, col_span};
      OP_VSPAN: rem_init = row_span;
      default:  rem_init = '0;
    endcase
  end

  // byte mask and address step for the word being issued
  always_comb begin
    lo = first ? req_q.x_start[2:0] : 3'd0;
    hi = (rem == '0) ? req_q.x_end[2:0] : 3'd7;
    if (req_q.op == OP_HSPAN) begin
      mask = (8'hFF >> lo) & (8'hFF << (3'd7 - hi));
    end else begin
      mask = 8'h80 >> req_q.x_start[2:0];
    end
    step = (req_q.op == OP_VSPAN) ? AW'(LINE_BYTES) : AW'(1);
  end

  // modify: rd_data arrives in the cycle after the read was issued
  always_comb begin
    m_word = spread_mask(p_mask);
    c_word = color_lanes(req_q.color);
    if (draw_mode) begin
      wr_data = rd_data ^ (c_word & m_word);
    end else begin
      wr_data = (rd_data & ~m_word) | (c_word & m_word);
    end
    for (int k = 0; k < 4; k++) begin
      pix[k] = |(rd_data[8*k +: 8] & p_mask);
    end
    if (state == S_CLEAR) begin
      wr_data = '0;
    end
  end

  assign rd_en     = (state == S_RUN);
  assign rd_addr   = addr;
  assign wr_en     = (state == S_CLEAR) || (p_valid && p_write);
  assign wr_addr   = (state == S_CLEAR) ? clr_addr : p_addr;
  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = '{pixel_value: value_q, bad_request: bad_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      p_valid  <= 1'b0;
    end else begin
      p_valid <= (state == S_RUN);
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (32'(clr_addr) == DEPTH - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= bad ? S_DONE : S_RUN;
        end
        S_RUN: begin
          if (rem == '0) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      req_q <= req;
    end
    if (state == S_CHECK) begin
      addr    <= base;
      rem     <= rem_init;
      first   <= 1'b1;
      bad_q   <= bad;
      value_q <= '0;
    end
    if (state == S_RUN) begin
      addr    <= addr + step;
      rem     <= rem - 9'd1;
      first   <= 1'b0;
      p_write <= (req_q.op != OP_READ_PIXEL);
      p_addr  <= addr;
      p_mask  <= mask;
    end
    if (p_valid && !p_write) begin
      value_q <= pix;
    end
  end

  pfre_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  a_pipe_state: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> (state == S_RUN || state == S_DRAIN))
    else $error("rmw stage busy outside a walk");

  a_drained: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!p_valid && !wr_en))
    else $error("result offered before write-back finished");

  a_last_word: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && rem == '0) |=> (state == S_DRAIN && p_valid))
    else $error("walk did not end after its last word");

  a_read_no_write: assert property (@(posedge clk) disable iff (rst)
    (p_valid && req_q.op == OP_READ_PIXEL) |-> !wr_en)
    else $error("pixel read wrote the store");

endmodule

`default_nettype wire

@@ tb/tb_planar_framebuffer_raster_engine_core.sv @@
// Self-checking bench for planar_framebuffer_raster_engine_core: pixel, span and read requests
// are checked against a behavioural copy of the four-plane store. Depends on pfre_pkg and the
// engine RTL only.
`timescale 1ns / 1ps

module tb_planar_framebuffer_raster_engine_core;
  import pfre_pkg::*;

  localparam int LINE_BYTES = LINE_BYTES_DEF;
  localparam int ROWS       = ROWS_DEF;
  localparam int PIX_COLS   = LINE_BYTES * 8;
  localparam int DEPTH      = LINE_BYTES * ROWS;
  // The clearing pass after reset, which writes all DEPTH words, is quiet.
  localparam int QUIET_LIMIT = 120000;
  localparam int PRINT_CAP   = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;  // x_start, x_end, y_start, y_end, color, zero pad
  logic [1:0]  s_tuser = '0;  // op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;       // pixel_value, zero pad
  logic        m_tuser;       // bad_request

  planar_framebuffer_raster_engine_core uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  // Shadow of the framebuffer and the mode register.
  logic [31:0] plane_words [DEPTH];
  logic        draw_xor = 1'b0;
  res_t        expected_replies [$];
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hot_x = 0;
  int          hot_y = 0;
  int          quiet_cycles = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic void plane_update(input int unsigned idx, input logic [7:0] bmask,
                                       input logic [3:0] color);
    logic [31:0] lanes;
    logic [31:0] ink;
    lanes = {bmask, bmask, bmask, bmask};
    ink = {{8{color[3]}}, {8{color[2]}}, {8{color[1]}}, {8{color[0]}}};
    if (draw_xor)
      plane_words[idx] = plane_words[idx] ^ (ink & lanes);
    else
      plane_words[idx] = (plane_words[idx] & ~lanes) | (ink & lanes);
  endfunction

  // Applies one request to the shadow store and returns the reply it should give.
  function automatic res_t predict_raster(input req_t r);
    res_t        res;
    logic        refused;
    int unsigned col;
    int unsigned last_col;
    int unsigned lo;
    int unsigned hi;
    logic [7:0]  pmask;
    logic [7:0]  bmask;
    logic [31:0] w;
    res = '0;
    refused = (r.x_start >= PIX_COLS) || (r.y_start >= ROWS);
    if (r.op == OP_HSPAN)
      refused = refused || (r.x_end >= PIX_COLS) || (r.x_end < r.x_start);
    if (r.op == OP_VSPAN)
      refused = refused || (r.y_end >= ROWS) || (r.y_end < r.y_start);
    res.bad_request = refused;
    if (refused)
      return res;
    col = 32'(r.x_start[9:3]);
    pmask = 8'h80 >> r.x_start[2:0];
    case (r.op)
      OP_DRAW_PIXEL: plane_update(32'(r.y_start) * LINE_BYTES + col, pmask, r.color);
      OP_READ_PIXEL: begin
        w = plane_words[32'(r.y_start) * LINE_BYTES + col];
        for (int k = 0; k < 4; k++)
          res.pixel_value[k] = |(w[8*k +: 8] & pmask);
      end
      OP_HSPAN: begin
        last_col = 32'(r.x_end[9:3]);
        for (int unsigned b = col; b <= last_col; b++) begin
          lo = (b == col) ? 32'(r.x_start[2:0]) : 32'd0;
          hi = (b == last_col) ? 32'(r.x_end[2:0]) : 32'd7;
          bmask = (8'hFF >> lo) & (8'hFF << (7 - hi));
          plane_update(32'(r.y_start) * LINE_BYTES + b, bmask, r.color);
        end
      end
      default: begin
        for (int unsigned y = 32'(r.y_start); y <= 32'(r.y_end); y++)
          plane_update(y * LINE_BYTES + col, pmask, r.color);
      end
    endcase
    return res;
  endfunction

  function automatic req_t make_req(input logic [1:0] op, input int xs, input int xe,
                                    input int ys, input int ye, input int color);
    req_t r;
    r.op = op;
    r.x_start = 10'(xs);
    r.x_end = 10'(xe);
    r.y_start = 9'(ys);
    r.y_end = 9'(ye);
    r.color = 4'(color);
    return r;
  endfunction

  // One request beat; the reply is predicted before the beat is offered.
  task automatic send_request(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    expected_replies.push_back(predict_raster(r));
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, r.color, r.y_end, r.y_start, r.x_end, r.x_start};
    s_tuser <= r.op;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain_replies();
    s_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_draw_mode(input logic [31:0] word);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_DRAW_MODE;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    draw_xor = word[0];
  endtask

  // Receiver back-pressure.
  always @(posedge clk)
    m_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("reply beat with nothing pending", {24'd0, m_tdata}, 32'd0);
      end else begin
        want = expected_replies.pop_front();
        if (m_tdata[3:0] !== want.pixel_value)
          report_mismatch("pixel_value", 32'(m_tdata[3:0]), 32'(want.pixel_value));
        if (m_tdata[7:4] !== 4'd0)
          report_mismatch("tdata pad", 32'(m_tdata[7:4]), 32'd0);
        if (m_tuser !== want.bad_request)
          report_mismatch("bad_request", 32'(m_tuser), 32'(want.bad_request));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int pick_col();
    int s;
    s = $urandom_range(99);
    if (s < 55) return hot_x + $urandom_range(31);
    if (s < 85) return $urandom_range(PIX_COLS - 1);
    if (s < 91) begin
      case ($urandom_range(4))
        0: return 0;
        1: return 7;
        2: return 8;
        3: return PIX_COLS - 8;
        default: return PIX_COLS - 1;
      endcase
    end
    return $urandom_range(1023);
  endfunction

  function automatic int pick_row();
    int s;
    s = $urandom_range(99);
    if (s < 55) return hot_y + $urandom_range(15);
    if (s < 85) return $urandom_range(ROWS - 1);
    if (s < 91) return $urandom_range(1) ? ROWS - 1 : 0;
    return $urandom_range(511);
  endfunction

  function automatic req_t random_req();
    int s;
    int xs;
    int xe;
    int ys;
    int ye;
    logic [1:0] op;
    s = $urandom_range(99);
    op = (s < 30) ? OP_DRAW_PIXEL : (s < 65) ? OP_READ_PIXEL : (s < 85) ? OP_HSPAN : OP_VSPAN;
    xs = pick_col();
    ys = pick_row();
    s = $urandom_range(99);
    // Ends mostly just past the start; some long, some arbitrary.
    if (s < 75) begin
      xe = xs + $urandom_range(40);
      ye = ys + $urandom_range(20);
    end else if (s < 85) begin
      xe = xs + $urandom_range(PIX_COLS - 1);
      ye = ys + $urandom_range(ROWS - 1);
    end else begin
      xe = $urandom_range(1023);
      ye = $urandom_range(511);
    end
    if (xe > 1023) xe = 1023;
    if (ye > 511) ye = 511;
    return make_req(op, xs, xe, ys, ye, $urandom_range(15));
  endfunction

  task automatic test_pixel_extremes();
    send_request(make_req(OP_DRAW_PIXEL, 0, $urandom_range(1023), 0, $urandom_range(511), 15));
    send_request(make_req(OP_READ_PIXEL, 0, $urandom_range(1023), 0, $urandom_range(511),
                          $urandom_range(15)));
    send_request(make_req(OP_DRAW_PIXEL, PIX_COLS - 1, 0, ROWS - 1, 0, 10));
    send_request(make_req(OP_READ_PIXEL, PIX_COLS - 1, 1023, ROWS - 1, 511, 0));
    send_request(make_req(OP_READ_PIXEL, PIX_COLS - 2, 0, ROWS - 1, 0, 15));
    // out-of-range column and row
    send_request(make_req(OP_DRAW_PIXEL, PIX_COLS, 0, 0, 0, 15));
    send_request(make_req(OP_READ_PIXEL, 0, 0, ROWS, 0, 0));
    send_request(make_req(OP_DRAW_PIXEL, 1023, 1023, 511, 511, 15));
  endtask

  task automatic test_span_cases();
    send_request(make_req(OP_HSPAN, 0, PIX_COLS - 1, ROWS - 1, $urandom_range(511), 5));
    send_request(make_req(OP_HSPAN, 3, 5, 0, $urandom_range(511), 9));
    // end before start, and end off the screen
    send_request(make_req(OP_HSPAN, 100, 99, 20, 0, 7));
    send_request(make_req(OP_HSPAN, 600, PIX_COLS, 20, 0, 7));
    send_request(make_req(OP_VSPAN, PIX_COLS - 1, $urandom_range(1023), 0, ROWS - 1, 12));
    send_request(make_req(OP_VSPAN, 30, 0, 10, 9, 3));
    send_request(make_req(OP_VSPAN, 30, 0, 0, ROWS, 3));
    send_request(make_req(OP_READ_PIXEL, PIX_COLS - 1, 0, 200, 0, 0));
    send_request(make_req(OP_READ_PIXEL, 4, 0, 0, 0, 0));
  endtask

  task automatic test_xor_mode();
    drain_replies();
    write_draw_mode(32'd1);
    send_request(make_req(OP_DRAW_PIXEL, 4, 0, 0, 0, 6));
    send_request(make_req(OP_READ_PIXEL, 4, 0, 0, 0, 0));
    send_request(make_req(OP_HSPAN, 0, PIX_COLS - 1, 0, 0, 15));
    send_request(make_req(OP_READ_PIXEL, 0, 0, 0, 0, 0));
    send_request(make_req(OP_VSPAN, 0, 0, 0, ROWS - 1, 3));
    send_request(make_req(OP_READ_PIXEL, 0, 0, ROWS - 1, 0, 0));
  endtask

  task automatic test_random_phase(input int n, input int idle_pct, input int stall_pct,
                                   input logic [31:0] mode_word);
    drain_replies();
    write_draw_mode(mode_word);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    hot_x = $urandom_range(PIX_COLS - 32);
    hot_y = $urandom_range(ROWS - 16);
    repeat (n) send_request(random_req());
  endtask

  initial begin
    foreach (plane_words[i]) plane_words[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_pixel_extremes();
    test_span_cases();
    test_xor_mode();
    // upper bits of the mode word must be ignored
    test_random_phase(356, 0, 0, 32'd0);
    test_random_phase(356, 60, 0, 32'd1);
    test_random_phase(356, 0, 60, 32'hFFFF_FFFE);
    test_random_phase(356, 19, 19, 32'hFFFF_FFFF);
    drain_replies();
    repeat (30) @(posedge clk);
    if (expected_replies.size() != 0)
      report_mismatch("replies still pending", expected_replies.size(), 32'd0);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
